@@ rtl/core/mpe_pkg.sv @@
// ----------------------------------------------------------------------------
// MLFQS priority engine package
// Shared types, register indexes and constants for the scheduler core.
// ----------------------------------------------------------------------------
package mpe_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MLFQS_ENABLE     = 3'd0;
  localparam logic [2:0] REG_ACTIVE_MASK      = 3'd1;
  localparam logic [2:0] REG_NICE_TABLE       = 3'd2;
  localparam logic [2:0] REG_HIGHEST_PRIORITY = 3'd3;
  localparam logic [2:0] REG_SECOND_TICKS     = 3'd4;
  localparam logic [2:0] REG_SLICE_TICKS      = 3'd5;

  // Fixed constants of the scheduler arithmetic.
  localparam int LOAD_DIV   = 60;
  localparam int CPU_SCALE  = 100;
  localparam int NICE_W     = 6;
  localparam int NICE_SLOTS = 8;

  // Reciprocals of 15 for the divisions by 60, applied after a right shift
  // by two. The load path is exact for shifted operands below 2^30 and the
  // ready path for shifted operands below 2^19.
  localparam int          RECIP_LOAD_SH  = 34;
  localparam logic [30:0] RECIP_LOAD     = 31'd1145324613;
  localparam int          RECIP_READY_SH = 23;
  localparam logic [19:0] RECIP_READY    = 20'd559241;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RUN_INC,
    ST_LOAD_MUL,
    ST_LOAD_SET,
    ST_COEF_GO,
    ST_DIV_COEF,
    ST_SEC_MUL,
    ST_SEC_WR,
    ST_PRI,
    ST_OUT_MUL,
    ST_OUT_FIN
  } state_t;

  typedef struct packed {
    logic        mlfqs_enable;
    logic [7:0]  active_mask;
    logic [47:0] nice_table;
    logic [5:0]  highest_priority;
    logic [9:0]  second_ticks;
    logic [7:0]  slice_ticks;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic rc_inc;
    logic load_mul;
    logic div_start;
    logic load_set;
    logic slot_clear;
    logic slot_step;
    logic sec_mul;
    logic sec_wr;
    logic pri_wr;
    logic out_mul;
    logic out_fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sec_fire;
    logic pri_fire;
    logic div_done;
    logic slot_last;
    logic out_free;
  } ctrl_stat_t;

  // Saturate a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat_rc(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/mpe_if.sv @@
// ----------------------------------------------------------------------------
// MLFQS priority engine channels
// Tick request channel and result channel with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mpe_tick_if;
  logic       valid;
  logic       ready;
  logic [2:0] run_slot;
  logic       running_idle;
  logic [3:0] ready_count;
  logic       new_slice;
  logic [2:0] query_thread;

  modport source(output valid, run_slot, running_idle, ready_count, new_slice,
                 query_thread, input ready);
  modport sink(input valid, run_slot, running_idle, ready_count, new_slice,
               query_thread, output ready);
endinterface

interface mpe_result_if;
  logic               valid;
  logic               ready;
  logic               yield_now;
  logic [9:0]         load_x100;
  logic signed [23:0] running_cpu_x100;
  logic [5:0]         running_priority;
  logic [5:0]         query_priority;
  logic               second_update;
  logic               priority_update;

  modport source(output valid, yield_now, load_x100, running_cpu_x100,
                 running_priority, query_priority, second_update, priority_update,
                 input ready);
  modport sink(input valid, yield_now, load_x100, running_cpu_x100,
               running_priority, query_priority, second_update, priority_update,
               output ready);
endinterface

@@ rtl/core/mpe_div.sv @@
// ----------------------------------------------------------------------------
// MLFQS priority engine divider
// Unsigned restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpe_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             ge;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    shifted = {rem, quo[NUM_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    ge      = !diff[DEN_W+1];
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end
endmodule

@@ rtl/core/mpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// MLFQS priority engine controller
// Sequences the per-tick work: cpu charge, load and decay, priorities, result.
// ----------------------------------------------------------------------------
module mpe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  output logic               tick_ready,
  input  mpe_pkg::ctrl_stat_t stat,
  output mpe_pkg::ctrl_cmd_t  cmd
);
  mpe_pkg::state_t state;
  mpe_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    tick_ready = 1'b0;
    case (state)
      mpe_pkg::ST_IDLE: begin
        tick_ready = 1'b1;
        if (tick_valid) begin
          cmd.accept = 1'b1;
          state_next = mpe_pkg::ST_RUN_INC;
        end
      end
      mpe_pkg::ST_RUN_INC: begin
        cmd.rc_inc = 1'b1;
        if (stat.sec_fire) begin
          state_next = mpe_pkg::ST_LOAD_MUL;
        end else if (stat.pri_fire) begin
          cmd.slot_clear = 1'b1;
          state_next     = mpe_pkg::ST_PRI;
        end else begin
          state_next = mpe_pkg::ST_OUT_MUL;
        end
      end
      mpe_pkg::ST_LOAD_MUL: begin
        cmd.load_mul = 1'b1;
        state_next   = mpe_pkg::ST_LOAD_SET;
      end
      mpe_pkg::ST_LOAD_SET: begin
        cmd.load_set = 1'b1;
        state_next   = mpe_pkg::ST_COEF_GO;
      end
      mpe_pkg::ST_COEF_GO: begin
        cmd.div_start = 1'b1;
        state_next    = mpe_pkg::ST_DIV_COEF;
      end
      mpe_pkg::ST_DIV_COEF: begin
        if (stat.div_done) begin
          cmd.slot_clear = 1'b1;
          state_next     = mpe_pkg::ST_SEC_MUL;
        end
      end
      mpe_pkg::ST_SEC_MUL: begin
        cmd.sec_mul = 1'b1;
        state_next  = mpe_pkg::ST_SEC_WR;
      end
      mpe_pkg::ST_SEC_WR: begin
        cmd.sec_wr = 1'b1;
        if (!stat.slot_last) begin
          cmd.slot_step = 1'b1;
          state_next    = mpe_pkg::ST_SEC_MUL;
        end else if (stat.pri_fire) begin
          cmd.slot_clear = 1'b1;
          state_next     = mpe_pkg::ST_PRI;
        end else begin
          state_next = mpe_pkg::ST_OUT_MUL;
        end
      end
      mpe_pkg::ST_PRI: begin
        cmd.pri_wr = 1'b1;
        if (stat.slot_last) begin
          state_next = mpe_pkg::ST_OUT_MUL;
        end else begin
          cmd.slot_step = 1'b1;
        end
      end
      mpe_pkg::ST_OUT_MUL: begin
        cmd.out_mul = 1'b1;
        state_next  = mpe_pkg::ST_OUT_FIN;
      end
      mpe_pkg::ST_OUT_FIN: begin
        if (stat.out_free) begin
          cmd.out_fin = 1'b1;
          state_next  = mpe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mpe_pkg::ST_IDLE;
      end
    endcase
  end
endmodule

@@ rtl/core/mpe_datapath.sv @@
// ----------------------------------------------------------------------------
// MLFQS priority engine datapath
// Per-slot tables, load average, phase counters, divider and result register.
// ----------------------------------------------------------------------------
module mpe_datapath #(
  parameter int THREAD_SLOTS  = 8,
  parameter int FRACTION_BITS = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  mpe_pkg::cfg_t       cfg,
  input  mpe_pkg::ctrl_cmd_t  cmd,
  output mpe_pkg::ctrl_stat_t stat,
  input  logic [2:0]          run_slot,
  input  logic                running_idle,
  input  logic [3:0]          ready_count,
  input  logic                new_slice,
  input  logic [2:0]          query_thread,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                yield_now,
  output logic [9:0]          load_x100,
  output logic signed [23:0]  running_cpu_x100,
  output logic [5:0]          running_priority,
  output logic [5:0]          query_priority,
  output logic                second_update,
  output logic                priority_update
);
  // Only the first eight slots can ever be addressed or activated.
  localparam int NSLOT = (THREAD_SLOTS < mpe_pkg::NICE_SLOTS) ? THREAD_SLOTS
                                                               : mpe_pkg::NICE_SLOTS;
  localparam int SW    = $clog2(NSLOT);
  localparam int NUM_W = 32 + FRACTION_BITS;
  localparam int DEN_W = 33;
  localparam int PW    = FRACTION_BITS + 33;
  localparam logic signed [63:0] FONE = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] FHALF = FONE >>> 1;

  // Tables and scalar state.
  logic signed [31:0] rc_tab [NSLOT];
  logic [5:0]         pri_tab [NSLOT];
  logic signed [31:0] load;
  logic [9:0]         second_phase;
  logic [7:0]         priority_phase;
  logic [7:0]         slice_count;

  // Latched request fields and tick flags.
  logic [2:0] run_q;
  logic       idle_q;
  logic [3:0] ready_q;
  logic [2:0] query_q;
  logic       yield_q;
  logic       sec_q;
  logic       pri_q;

  // Working registers.
  logic [SW-1:0]            slot;
  logic [31:0]              qa;
  logic [31:0]              qb;
  logic [FRACTION_BITS-1:0] coef;
  logic signed [PW-1:0]     prod_q;
  logic [63:0]              load_prod_q;
  logic signed [63:0]       cpu_prod_q;
  logic [5:0]               run_pri_q;

  // Divider interface.
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quo;
  logic             div_done;

  logic              run_ok;
  logic              query_ok;
  logic [SW-1:0]     rd_addr;
  logic signed [31:0] rd_rc;
  logic [5:0]        rd_pri;
  logic [63:0]       load_u;
  logic [63:0]       twol;
  logic [4:0]        ready_tot;
  logic [32:0]       load_up;
  logic [61:0]       load_prd;
  logic [31:0]       load_keep;
  logic [20:0]       rdy_fix;
  logic [39:0]       rdy_prd;
  logic [31:0]       rdy_part;
  logic [10:0]       sec_n;
  logic [8:0]        pri_n;
  logic [7:0]        slice_base;
  logic [7:0]        slice_new;
  logic              sec_hit;
  logic              pri_hit;
  logic signed [63:0] slot_nice;
  logic              slot_act;
  logic signed [63:0] sec_v;
  logic signed [63:0] pri_v;
  logic [5:0]        pri_new;
  logic [63:0]       load_x;
  logic signed [63:0] cpu_x;
  logic signed [63:0] cpu_r;
  logic signed [23:0] cpu_sat;

  // Truncating shift that rounds toward zero like a signed divide.
  function automatic logic signed [63:0] tshift(input logic signed [63:0] v,
                                                input int sh);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (v + bias) >>> sh;
  endfunction

  assign run_ok   = int'(run_q) < NSLOT;
  assign query_ok = int'(query_q) < NSLOT;

  // Single read port of the slot tables.
  always_comb begin
    if (cmd.rc_inc || cmd.out_mul) begin
      rd_addr = run_q[SW-1:0];
    end else if (cmd.out_fin) begin
      rd_addr = query_q[SW-1:0];
    end else begin
      rd_addr = slot;
    end
    rd_rc  = rc_tab[rd_addr];
    rd_pri = pri_tab[rd_addr];
  end

  // Nice value and active bit of the slot under the sweep.
  always_comb begin
    logic [2:0] k;
    logic [mpe_pkg::NICE_W-1:0] nb;
    k         = 3'(slot);
    nb        = cfg.nice_table[k*mpe_pkg::NICE_W +: mpe_pkg::NICE_W];
    slot_nice = 64'(signed'(nb));
    slot_act  = cfg.active_mask[k];
  end

  // Phase counters and slice counter for the incoming tick.
  always_comb begin
    sec_n      = {1'b0, second_phase} + 11'd1;
    pri_n      = {1'b0, priority_phase} + 9'd1;
    sec_hit    = sec_n >= {1'b0, cfg.second_ticks};
    pri_hit    = pri_n >= {1'b0, cfg.slice_ticks};
    slice_base = new_slice ? 8'd0 : slice_count;
    slice_new  = (slice_base == 8'd255) ? slice_base : slice_base + 8'd1;
  end

  // Load update terms. The load is never negative, so load*59/60 equals
  // load - ceil(load/60); both divisions by 60 are a shift by two followed
  // by a reciprocal multiply by 1/15.
  always_comb begin
    ready_tot = {1'b0, ready_q} + {4'b0, !idle_q};
    load_up   = {1'b0, load} + 33'(mpe_pkg::LOAD_DIV - 1);
    load_prd  = 62'(load_up[32:2]) * 62'(mpe_pkg::RECIP_LOAD);
    load_keep = load - 32'(load_prd >> mpe_pkg::RECIP_LOAD_SH);
    rdy_fix   = 21'(ready_tot) << FRACTION_BITS;
    rdy_prd   = 40'(rdy_fix[20:2]) * 40'(mpe_pkg::RECIP_READY);
    rdy_part  = 32'(rdy_prd >> mpe_pkg::RECIP_READY_SH);
  end

  // Divider operands for the decay coefficient 2L*F/(2L+F).
  always_comb begin
    load_u  = {32'b0, load};
    twol    = load_u << 1;
    div_num = NUM_W'(twol << FRACTION_BITS);
    div_den = DEN_W'(twol + 64'(FONE));
  end

  mpe_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .done (div_done)
  );

  // Recent cpu decay and priority formulas for the slot under the sweep.
  always_comb begin
    sec_v = tshift(64'(prod_q), FRACTION_BITS) + (slot_nice <<< FRACTION_BITS);
    pri_v = $signed({58'b0, cfg.highest_priority})
          - tshift(64'(rd_rc), FRACTION_BITS + 2) - (slot_nice <<< 1);
    if (pri_v < 64'sd0) begin
      pri_new = 6'd0;
    end else if (pri_v > $signed({58'b0, cfg.highest_priority})) begin
      pri_new = cfg.highest_priority;
    end else begin
      pri_new = pri_v[5:0];
    end
  end

  // Rounding and saturation of the reported values.
  always_comb begin
    load_x = (load_prod_q + 64'(FHALF)) >> FRACTION_BITS;
    if (cpu_prod_q >= 64'sd0) begin
      cpu_x = (cpu_prod_q + FHALF) >>> FRACTION_BITS;
    end else begin
      cpu_x = -((-cpu_prod_q + FHALF) >>> FRACTION_BITS);
    end
    cpu_r = cpu_x;
    if (cpu_r > 64'sd8388607) begin
      cpu_sat = 24'sh7fffff;
    end else if (cpu_r < -64'sd8388608) begin
      cpu_sat = 24'sh800000;
    end else begin
      cpu_sat = cpu_r[23:0];
    end
  end

  // Control state: counters, tables, load and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      second_phase   <= '0;
      priority_phase <= '0;
      slice_count    <= '0;
      load           <= '0;
      sec_q          <= 1'b0;
      pri_q          <= 1'b0;
      yield_q        <= 1'b0;
      slot           <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < NSLOT; i++) begin
        rc_tab[i]  <= '0;
        pri_tab[i] <= 6'd63;
      end
    end else begin
      if (cmd.accept) begin
        second_phase   <= sec_hit ? 10'd0 : sec_n[9:0];
        priority_phase <= pri_hit ? 8'd0 : pri_n[7:0];
        slice_count    <= slice_new;
        yield_q        <= slice_new >= cfg.slice_ticks;
        sec_q          <= sec_hit && cfg.mlfqs_enable;
        pri_q          <= pri_hit && cfg.mlfqs_enable;
      end
      // Charge the running thread for this tick.
      if (cmd.rc_inc && cfg.mlfqs_enable && !idle_q && run_ok) begin
        rc_tab[rd_addr] <= mpe_pkg::sat_rc(64'(rd_rc) + FONE);
      end
      if (cmd.load_set) begin
        load <= mpe_pkg::sat_rc($signed(64'(qa) + 64'(qb)));
      end
      if (cmd.slot_clear) begin
        slot <= '0;
      end else if (cmd.slot_step) begin
        slot <= slot + 1'b1;
      end
      if (cmd.sec_wr && slot_act) begin
        rc_tab[slot] <= mpe_pkg::sat_rc(sec_v);
      end
      if (cmd.pri_wr && slot_act) begin
        pri_tab[slot] <= pri_new;
      end
      // Result register: filled when the tick is done, emptied on take.
      if (cmd.out_fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      run_q   <= run_slot;
      idle_q  <= running_idle;
      ready_q <= ready_count;
      query_q <= query_thread;
    end
    if (cmd.load_mul) begin
      qa <= load_keep;
      qb <= rdy_part;
    end
    if (div_done) begin
      coef <= div_quo[FRACTION_BITS-1:0];
    end
    if (cmd.sec_mul) begin
      prod_q <= $signed({1'b0, coef}) * rd_rc;
    end
    if (cmd.out_mul) begin
      load_prod_q <= {32'b0, load[31:0]} * 64'(mpe_pkg::CPU_SCALE);
      cpu_prod_q  <= 64'(rd_rc) * 64'sd100;
      run_pri_q   <= rd_pri;
    end
    if (cmd.out_fin) begin
      yield_now        <= yield_q;
      load_x100        <= (load_x > 64'd1023) ? 10'd1023 : load_x[9:0];
      running_cpu_x100 <= run_ok ? cpu_sat : 24'sd0;
      running_priority <= run_ok ? run_pri_q : 6'd0;
      query_priority   <= query_ok ? rd_pri : 6'd0;
      second_update    <= sec_q;
      priority_update  <= pri_q;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.sec_fire  = sec_q;
    stat.pri_fire  = pri_q;
    stat.div_done  = div_done;
    stat.slot_last = int'(slot) == NSLOT - 1;
    stat.out_free  = !out_valid || out_ready;
  end
endmodule

@@ rtl/core/mlfqs_priority_engine_core.sv @@
// ----------------------------------------------------------------------------
// MLFQS priority engine core
// Scheduler arithmetic of a multi-level feedback queue in 17.14 fixed point.
// ----------------------------------------------------------------------------
// Usage:
// The tick channel takes one timer tick per request: the running slot, its
// idle flag, the ready queue length, the slice restart flag and a slot to
// query. For each request one result request leaves on the result channel.
// An ordinary tick passes the charge, output multiply and output finish steps
// before its result is registered; no new tick is taken before that.
// A priority tick adds a priority sweep step for each thread slot.
// A second tick adds the load multiply and load set steps, a step to start the
// bit-serial divider, the coefficient divide, and a multiply and a write step
// per slot for the recent cpu decay, ahead of any priority sweep.
// A new tick is accepted while a finished result waits in the output
// register; if the receiver stalls, the next tick is held in its last step
// until the register frees.
// Reset clears recent cpu and load to zero, all priorities to 63 and the
// registers to their reset values. Registers sit on the APB port at 8*index
// and are to be written only while the block is idle.
// ----------------------------------------------------------------------------
module mlfqs_priority_engine_core #(
  parameter int THREAD_SLOTS  = 8,
  parameter int FRACTION_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  mpe_tick_if.sink    tick,
  mpe_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  mpe_pkg::cfg_t       cfg;
  mpe_pkg::ctrl_cmd_t  cmd;
  mpe_pkg::ctrl_stat_t stat;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mlfqs_enable     <= 1'b0;
      cfg.active_mask      <= '0;
      cfg.nice_table       <= '0;
      cfg.highest_priority <= 6'd63;
      cfg.second_ticks     <= 10'd100;
      cfg.slice_ticks      <= 8'd4;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        mpe_pkg::REG_MLFQS_ENABLE:     cfg.mlfqs_enable     <= pwdata[0];
        mpe_pkg::REG_ACTIVE_MASK:      cfg.active_mask      <= pwdata[7:0];
        mpe_pkg::REG_NICE_TABLE:       cfg.nice_table       <= pwdata[47:0];
        mpe_pkg::REG_HIGHEST_PRIORITY: cfg.highest_priority <= pwdata[5:0];
        mpe_pkg::REG_SECOND_TICKS:     cfg.second_ticks     <= pwdata[9:0];
        mpe_pkg::REG_SLICE_TICKS:      cfg.slice_ticks      <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      mpe_pkg::REG_MLFQS_ENABLE:     prdata = 64'(cfg.mlfqs_enable);
      mpe_pkg::REG_ACTIVE_MASK:      prdata = 64'(cfg.active_mask);
      mpe_pkg::REG_NICE_TABLE:       prdata = 64'(cfg.nice_table);
      mpe_pkg::REG_HIGHEST_PRIORITY: prdata = 64'(cfg.highest_priority);
      mpe_pkg::REG_SECOND_TICKS:     prdata = 64'(cfg.second_ticks);
      mpe_pkg::REG_SLICE_TICKS:      prdata = 64'(cfg.slice_ticks);
      default:                       prdata = '0;
    endcase
  end

  mpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tick_valid(tick.valid),
    .tick_ready(tick.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mpe_datapath #(
    .THREAD_SLOTS (THREAD_SLOTS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .run_slot        (tick.run_slot),
    .running_idle    (tick.running_idle),
    .ready_count     (tick.ready_count),
    .new_slice       (tick.new_slice),
    .query_thread    (tick.query_thread),
    .out_ready       (result.ready),
    .out_valid       (result.valid),
    .yield_now       (result.yield_now),
    .load_x100       (result.load_x100),
    .running_cpu_x100(result.running_cpu_x100),
    .running_priority(result.running_priority),
    .query_priority  (result.query_priority),
    .second_update   (result.second_update),
    .priority_update (result.priority_update)
  );
endmodule

@@ bench/tb_mlfqs_priority_engine_core.sv @@
// ----------------------------------------------------------------------------
// Testbench for the MLFQS priority engine core
// Drives timer tick requests through phases of register settings and checks
// every result request against a fixed-point scheduler predictor kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mlfqs_priority_engine_core;

  localparam int  SLOTS      = 8;
  localparam int  FRAC       = 14;
  localparam longint FONE    = longint'(1) << FRAC;
  localparam int  IDLE_LIMIT = 4000;
  localparam int  PHASES     = 12;

  typedef struct packed {
    logic [2:0] run;
    logic       idle;
    logic [3:0] ready;
    logic       fresh;
    logic [2:0] query;
  } tick_req_t;

  typedef struct packed {
    logic        yield_now;
    logic [9:0]  load_x100;
    logic [23:0] cpu_x100;
    logic [5:0]  run_pri;
    logic [5:0]  query_pri;
    logic        sec_upd;
    logic        pri_upd;
  } sched_res_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  mpe_tick_if   tick ();
  mpe_result_if result ();

  mlfqs_priority_engine_core u_dut (
    .clk(clk), .rst(rst), .tick(tick.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Scheduler state mirrored by the predictor.
  logic        cfg_enable;
  logic [7:0]  cfg_mask;
  logic [47:0] cfg_nice;
  logic [5:0]  cfg_highest;
  logic [9:0]  cfg_sec_ticks;
  logic [7:0]  cfg_slice_ticks;
  longint      cpu_tab [SLOTS];
  longint      prio [SLOTS];
  longint      load_fix;
  int unsigned sec_phase, pri_phase, slice_cnt;

  tick_req_t  pending_ticks [$];
  sched_res_t expected_results [$];

  int     mismatches = 0;
  int     ticks_sent = 0;
  int     results_seen = 0;
  int     second_updates = 0;
  int     priority_updates = 0;
  bit     idling_on = 1'b0;
  int     src_gap = 0;
  int     snk_gap = 0;
  int     quiet_cycles = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clampv(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_fix(input longint x);
    return x >= 0 ? (x + FONE / 2) / FONE : (x - FONE / 2) / FONE;
  endfunction

  function automatic longint nice_of(input int i);
    longint b;
    b = longint'((cfg_nice >> (6 * i)) & 48'h3f);
    return (b & 32) != 0 ? b - 64 : b;
  endfunction

  function automatic bit advance_phase(inout int unsigned ph, input int unsigned period);
    int unsigned nxt;
    nxt = ph + 1;
    if (nxt >= period) begin
      ph = 0;
      return 1'b1;
    end
    ph = nxt & 1023;
    return 1'b0;
  endfunction

  // Apply one timer tick to the mirrored state and work out its result.
  function automatic sched_res_t schedule_tick(input tick_req_t t);
    sched_res_t r;
    bit         sec, pri;
    longint     ready, v, twol, den, coef;
    sec = advance_phase(sec_phase, cfg_sec_ticks);
    pri = advance_phase(pri_phase, cfg_slice_ticks);
    ready = t.ready;
    if (t.fresh) slice_cnt = 0;
    if (slice_cnt < 255) slice_cnt++;
    r.yield_now = slice_cnt >= cfg_slice_ticks;
    if (!cfg_enable) begin
      sec = 1'b0;
      pri = 1'b0;
    end else begin
      if (!t.idle) cpu_tab[t.run] = sat32(cpu_tab[t.run] + FONE);
      if (sec) begin
        if (!t.idle) ready++;
        load_fix = sat32(load_fix * 59 / 60 + ready * FONE / 60);
        twol = 2 * load_fix;
        den = twol + FONE;
        coef = den > 0 ? twol * FONE / den : 0;
        for (int i = 0; i < SLOTS; i++)
          if (cfg_mask[i])
            cpu_tab[i] = sat32(coef * cpu_tab[i] / FONE + nice_of(i) * FONE);
      end
      if (pri) begin
        for (int i = 0; i < SLOTS; i++)
          if (cfg_mask[i]) begin
            v = longint'(cfg_highest) - (cpu_tab[i] / 4) / FONE - 2 * nice_of(i);
            prio[i] = clampv(v, 0, longint'(cfg_highest));
          end
      end
    end
    r.load_x100 = 10'(clampv(round_fix(load_fix * 100), 0, 1023));
    r.cpu_x100  = 24'(clampv(round_fix(cpu_tab[t.run] * 100), -8388608, 8388607));
    r.run_pri   = 6'(prio[t.run]);
    r.query_pri = 6'(prio[t.query]);
    r.sec_upd   = sec;
    r.pri_upd   = pri;
    return r;
  endfunction

  // Tick driver: sends queued requests, with random gaps while idling is on.
  always @(posedge clk) begin
    if (rst) begin
      tick.valid <= 1'b0;
    end else begin
      if (tick.valid && tick.ready) begin
        expected_results.push_back(schedule_tick({tick.run_slot, tick.running_idle,
                                                  tick.ready_count, tick.new_slice,
                                                  tick.query_thread}));
        ticks_sent++;
      end
      if (tick.valid && !tick.ready) begin
        // Hold the offered request until it is taken.
      end else if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        tick.valid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        src_gap <= $urandom_range(0, 14);
        tick.valid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        tick_req_t t;
        t = pending_ticks.pop_front();
        tick.valid <= 1'b1;
        tick.run_slot <= t.run;
        tick.running_idle <= t.idle;
        tick.ready_count <= t.ready;
        tick.new_slice <= t.fresh;
        tick.query_thread <= t.query;
      end else begin
        tick.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  // Result monitor: random stalls on ready while idling is on, field-by-field comparison.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("MISMATCH: result with no tick outstanding");
        end else begin
          sched_res_t e;
          e = expected_results.pop_front();
          check_field("yield_now", e.yield_now, result.yield_now);
          check_field("load_x100", e.load_x100, result.load_x100);
          check_field("running_cpu_x100", $signed(e.cpu_x100), result.running_cpu_x100);
          check_field("running_priority", e.run_pri, result.running_priority);
          check_field("query_priority", e.query_pri, result.query_priority);
          check_field("second_update", e.sec_upd, result.second_update);
          check_field("priority_update", e.pri_upd, result.priority_update);
          second_updates += e.sec_upd;
          priority_updates += e.pri_upd;
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        result.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        snk_gap <= $urandom_range(0, 14);
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without progress while work is outstanding.
  always @(posedge clk) begin
    if (!rst && (pending_ticks.size() > 0 || expected_results.size() > 0 || tick.valid)) begin
      if ((tick.valid && tick.ready) || (result.valid && result.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Register write over APB; the predictor takes the new value as well.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      mpe_pkg::REG_MLFQS_ENABLE:     cfg_enable = val[0];
      mpe_pkg::REG_ACTIVE_MASK:      cfg_mask = val[7:0];
      mpe_pkg::REG_NICE_TABLE:       cfg_nice = val[47:0];
      mpe_pkg::REG_HIGHEST_PRIORITY: cfg_highest = val[5:0];
      mpe_pkg::REG_SECOND_TICKS:     cfg_sec_ticks = val[9:0];
      mpe_pkg::REG_SLICE_TICKS:      cfg_slice_ticks = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic en, input logic [7:0] mask, input logic [47:0] nice,
                           input logic [5:0] hp, input logic [9:0] st, input logic [7:0] sl);
    write_reg(mpe_pkg::REG_MLFQS_ENABLE, 64'(en));
    write_reg(mpe_pkg::REG_ACTIVE_MASK, 64'(mask));
    write_reg(mpe_pkg::REG_NICE_TABLE, 64'(nice));
    write_reg(mpe_pkg::REG_HIGHEST_PRIORITY, 64'(hp));
    write_reg(mpe_pkg::REG_SECOND_TICKS, 64'(st));
    write_reg(mpe_pkg::REG_SLICE_TICKS, 64'(sl));
  endtask

  task automatic queue_tick(input int run, input bit idle, input int rdy, input bit fresh,
                            input int query);
    tick_req_t t;
    t.run = 3'(run);
    t.idle = idle;
    t.ready = 4'(rdy);
    t.fresh = fresh;
    t.query = 3'(query);
    pending_ticks.push_back(t);
  endtask

  task automatic wait_drained();
    wait (pending_ticks.size() == 0 && expected_results.size() == 0 && !tick.valid);
    repeat (8) @(posedge clk);
  endtask

  // Stimulus: directed phases, then random phases with random settings.
  initial begin
    logic [47:0] nice;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick.valid = 1'b0;
    tick.run_slot = '0;
    tick.running_idle = 1'b0;
    tick.ready_count = '0;
    tick.new_slice = 1'b0;
    tick.query_thread = '0;
    result.ready = 1'b0;
    cfg_enable = 1'b0;
    cfg_mask = '0;
    cfg_nice = '0;
    cfg_highest = 6'd63;
    cfg_sec_ticks = 10'd100;
    cfg_slice_ticks = 8'd4;
    for (int i = 0; i < SLOTS; i++) begin
      cpu_tab[i] = 0;
      prio[i] = 63;
    end
    load_fix = 0;
    sec_phase = 0;
    pri_phase = 0;
    slice_cnt = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: slice counting only, with and without slice restarts.
    for (int i = 0; i < 6; i++) queue_tick(i, i[0], i, i == 3, 7 - i);
    wait_drained();

    // Feedback on, every slot, extreme nice values, update every tick.
    write_all(1'b1, 8'hff, {6'd31, 6'd32, 6'd0, 6'd1, 6'd63, 6'd31, 6'd32, 6'd0},
              6'd63, 10'd1, 8'd1);
    for (int i = 0; i < 16; i++)
      queue_tick(i % 8, i % 5 == 4, (i % 3 == 0) ? 8 : i % 9, i % 4 == 0, (i * 3) % 8);
    wait_drained();

    // Random phases; the last one and every fourth from the second run without idling on either side.
    idling_on = 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      int n;
      int st, sl, hp;
      nice = 48'({$urandom(), $urandom()});
      st = $urandom_range(1, 12);
      sl = $urandom_range(1, 8);
      hp = $urandom_range(1, 63);
      n = 62;
      if (p == 2) begin
        st = 1000;
        sl = 255;
        hp = 1;
      end
      if (p == 3) hp = 63;
      if (p == 5) nice = 48'hfff_fff_fff_fff;
      write_all($urandom_range(0, 7) != 0, 8'($urandom()), nice, 6'(hp), 10'(st), 8'(sl));
      if (p == PHASES - 1) idling_on = 1'b0;
      else if (p % 4 == 1) idling_on = 1'b0;
      else idling_on = 1'b1;
      for (int i = 0; i < n; i++)
        queue_tick($urandom_range(0, 7), $urandom_range(0, 5) == 0, $urandom_range(0, 8),
                   $urandom_range(0, 6) == 0, $urandom_range(0, 7));
      wait_drained();
    end

    repeat (300) @(posedge clk);
    $display("Covered %0d ticks and %0d results over %0d setting phases,", ticks_sent,
             results_seen, PHASES + 2);
    $display("with %0d load/cpu updates and %0d priority sweeps.", second_updates,
             priority_updates);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mpe_pkg.sv
rtl/core/mpe_if.sv
rtl/core/mpe_div.sv
rtl/core/mpe_ctrl.sv
rtl/core/mpe_datapath.sv
rtl/core/mlfqs_priority_engine_core.sv
bench/tb_mlfqs_priority_engine_core.sv
